>>> hdl/npc_pkg.sv
// shared types and constants of the nth prime unit
package npc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int INDEX_BITS = 16;
	// the 65536th prime is 821641, so a scanned prime fits in 20 bits
	localparam int SCAN_BITS = 20;
	// index and fill count compare width
	localparam int CMP_BITS = INDEX_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

	localparam logic [VALUE_BITS-1:0] FIRST_ODD_DIVISOR = VALUE_BITS'(3);
	localparam logic [VALUE_BITS-1:0] SMALLEST_PRIME = VALUE_BITS'(2);

	typedef enum logic {
		FUNC_TEST  = 1'b0,
		FUNC_INDEX = 1'b1
	} func_t;

	typedef struct packed {
		logic                  func;
		logic [VALUE_BITS-1:0] test_value;
		logic [INDEX_BITS-1:0] prime_index;
	} in_beat_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] prime_value;
		logic                  is_prime;
	} out_beat_t;

	typedef struct packed {
		logic load_req;
		logic n_from_value;
		logic n_from_cand;
		logic d_init;
		logic d_next;
		logic div_start;
		logic div_step;
		logic mem_read;
		logic scan_init;
		logic cand_next;
		logic prime_found;
		logic ans_test;
		logic ans_bit;
		logic ans_mem;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic hit;
		logic n_lt2;
		logic n_eq2;
		logic n_even;
		logic div_done;
		logic q_lt_d;
		logic r_zero;
		logic k_eq_index;
	} status_t;

endpackage

>>> hdl/npc_datapath.sv
// datapath: request registers, trial divider, prime table and result registers
module npc_datapath #(
	parameter int CACHE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  npc_pkg::in_beat_t in_data,
	input  npc_pkg::cmd_t     cmd,
	output npc_pkg::status_t  status,
	output npc_pkg::out_beat_t out_data
);
	localparam int TW = npc_pkg::VALUE_BITS;
	localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CW = $clog2(CACHE_DEPTH + 1);
	localparam int SW = npc_pkg::SCAN_BITS;
	localparam int XW = npc_pkg::CMP_BITS;

	npc_pkg::in_beat_t req_q;
	logic [TW-1:0] n_q;
	logic [TW-1:0] d_q;
	logic [TW:0]   rem_q;
	logic [TW-1:0] quo_q;
	logic [npc_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [SW-1:0] cand_q;
	logic [SW-1:0] last_q;
	logic [npc_pkg::INDEX_BITS-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] rd_q;
	logic [SW-1:0] ans_val_q;
	logic          ans_prime_q;
	logic [SW-1:0] mem [CACHE_DEPTH];

	logic [TW:0] shifted;
	logic        fits;
	logic        store;
	logic [TW-1:0] ans_ext;

	assign shifted = {rem_q[TW-1:0], quo_q[TW-1]};
	assign fits    = shifted >= {1'b0, d_q};
	assign store   = cmd.prime_found && (XW'(k_q) == XW'(count_q))
		&& (XW'(count_q) < XW'(CACHE_DEPTH));
	assign ans_ext = TW'(ans_val_q);

	assign status.func       = req_q.func;
	assign status.hit        = XW'(req_q.prime_index) < XW'(count_q);
	assign status.n_lt2      = n_q < npc_pkg::SMALLEST_PRIME;
	assign status.n_eq2      = n_q == npc_pkg::SMALLEST_PRIME;
	assign status.n_even     = !n_q[0];
	assign status.div_done   = cnt_q == npc_pkg::DIV_CNT_BITS'(TW);
	assign status.q_lt_d     = quo_q < d_q;
	assign status.r_zero     = rem_q == '0;
	assign status.k_eq_index = k_q == req_q.prime_index;

	// table of primes found so far
	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[AW-1:0]] <= cand_q;
		end
		if (cmd.mem_read) begin
			rd_q <= mem[req_q.prime_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (store) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
		if (cmd.n_from_value) begin
			n_q <= req_q.test_value;
		end else if (cmd.n_from_cand) begin
			n_q <= TW'(cand_q);
		end
		if (cmd.d_init) begin
			d_q <= npc_pkg::FIRST_ODD_DIVISOR;
		end else if (cmd.d_next) begin
			d_q <= d_q + TW'(2);
		end
		// restoring division, one quotient bit a cycle
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? (shifted - {1'b0, d_q}) : shifted;
			quo_q <= {quo_q[TW-2:0], fits};
			cnt_q <= cnt_q + npc_pkg::DIV_CNT_BITS'(1);
		end
		if (cmd.scan_init) begin
			k_q    <= npc_pkg::INDEX_BITS'(count_q);
			cand_q <= (count_q == '0) ? SW'(2) : last_q + SW'(1);
		end else if (cmd.prime_found) begin
			k_q    <= k_q + npc_pkg::INDEX_BITS'(1);
			cand_q <= cand_q + SW'(1);
		end else if (cmd.cand_next) begin
			cand_q <= cand_q + SW'(1);
		end
		if (store) begin
			last_q <= cand_q;
		end
		if (cmd.ans_test) begin
			ans_val_q   <= '0;
			ans_prime_q <= cmd.ans_bit;
		end else if (cmd.ans_mem) begin
			ans_val_q   <= rd_q;
			ans_prime_q <= 1'b1;
		end else if (cmd.prime_found) begin
			ans_val_q   <= cand_q;
			ans_prime_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_data.prime_value <= ans_ext;
			out_data.is_prime    <= ans_prime_q;
		end
	end

endmodule

>>> hdl/npc_ctrl.sv
// controller state machine of the nth prime unit
module npc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  npc_pkg::status_t status,
	output npc_pkg::cmd_t    cmd
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_READ, ST_TEST, ST_START, ST_DIV, ST_EVAL, ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   verdict_valid;
	logic   verdict;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		verdict_valid = 1'b0;
		verdict       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.func == npc_pkg::FUNC_TEST) begin
					cmd.n_from_value = 1'b1;
					state_d          = ST_TEST;
				end else if (status.hit) begin
					cmd.mem_read = 1'b1;
					state_d      = ST_READ;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			// a table hit needs the registered read before the result moves on
			ST_READ: begin
				cmd.ans_mem = 1'b1;
				state_d     = ST_DONE;
			end
			ST_SCAN: begin
				cmd.n_from_cand = 1'b1;
				state_d         = ST_TEST;
			end
			ST_TEST: begin
				if (status.n_lt2 || (status.n_even && !status.n_eq2)) begin
					verdict_valid = 1'b1;
				end else if (status.n_eq2) begin
					verdict_valid = 1'b1;
					verdict       = 1'b1;
				end else begin
					cmd.d_init = 1'b1;
					state_d    = ST_START;
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_EVAL;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EVAL: begin
				if (status.q_lt_d) begin
					verdict_valid = 1'b1;
					verdict       = 1'b1;
				end else if (status.r_zero) begin
					verdict_valid = 1'b1;
				end else begin
					cmd.d_next = 1'b1;
					state_d    = ST_START;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (verdict_valid) begin
			if (status.func == npc_pkg::FUNC_TEST) begin
				cmd.ans_test = 1'b1;
				cmd.ans_bit  = verdict;
				state_d      = ST_DONE;
			end else if (verdict) begin
				cmd.prime_found = 1'b1;
				state_d         = status.k_eq_index ? ST_DONE : ST_SCAN;
			end else begin
				cmd.cand_next = 1'b1;
				state_d       = ST_SCAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DISPATCH)
		else $error("accepted beat not dispatched");
	a_div_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && status.div_done |=> state_q == ST_EVAL)
		else $error("finished division not evaluated");
	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not presented");

endmodule

>>> hdl/nth_prime_with_cache_unit.sv
// top level of the nth prime unit with prime table
// one beat at a time: a primality test takes the value through an evenness
// check and then trial division by odd divisors 3, 5, 7 ... up to its square
// root; each divisor costs one pass of the restoring divider (31 bit steps
// plus setup, finish and check). an index query that hits the table (index
// below the number of stored primes) answers through the table's registered
// read port. a miss scans candidates after the last stored prime, testing
// each one the same way and appending each new prime while the table has
// room; with a full table the scan starts again from the last stored prime
// on every miss. the result waits in an output register, and the next beat
// is taken once the unit is back idle. the table needs no clearing after
// reset: a fill count marks its valid part
module nth_prime_with_cache_unit #(
	parameter int CACHE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  npc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output npc_pkg::out_beat_t out_data
);
	// command and status between sequencer and datapath
	npc_pkg::cmd_t    cmd;
	npc_pkg::status_t status;

	// sequencer: dispatch, trial division loop, scan loop, result hand-off
	npc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: divider, candidate and index counters, prime table
	npc_datapath #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
